>>> rtl/data_eeprom_controller_defines.svh
// ----------------------------------------------------------------------------
// Data EEPROM controller assertion macros
// Shared assertion forms for the checker of the data EEPROM controller.
// ----------------------------------------------------------------------------
`ifndef DATA_EEPROM_CONTROLLER_DEFINES_SVH
`define DATA_EEPROM_CONTROLLER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DEE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("data EEPROM controller check failed");

// Clocked assertion that also holds during reset.
`define DEE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("data EEPROM controller check failed");

`endif

>>> rtl/dee_pkg.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller package
// Field widths, function and register codes and fixed constants.
// ----------------------------------------------------------------------------
package dee_pkg;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    localparam logic [INDEX_W-1:0] REG_ADDR_HI = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ADDR_LO = 3'd1;
    localparam logic [INDEX_W-1:0] REG_DATA    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_CONTROL = 3'd3;
    localparam logic [INDEX_W-1:0] REG_UNLOCK  = 3'd4;

    // Control register bit positions.
    localparam int CTL_RD   = 0;
    localparam int CTL_WR   = 1;
    localparam int CTL_WREN = 2;
    localparam int CTL_ERR  = 3;

    localparam logic [BYTE_W-1:0] UNLOCK_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] UNLOCK_SECOND = 8'hAA;
    localparam logic [BYTE_W-1:0] ERASED_BYTE   = 8'hFF;

    localparam logic [1:0] STAGE_LOCKED = 2'd0;
    localparam logic [1:0] STAGE_FIRST  = 2'd1;
    localparam logic [1:0] STAGE_OPEN   = 2'd2;

    localparam logic [TICK_W-1:0] WRITE_TIME_RESET = 16'd4000;

    // Configuration register word index.
    localparam logic [0:0] CFG_WRITE_TIME = 1'b0;

endpackage

>>> rtl/dee_cmd_if.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller channels
// Command channel into the controller and result channel out of it.
// ----------------------------------------------------------------------------
interface dee_cmd_if import dee_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] reg_index;
    logic [BYTE_W-1:0]  wdata;

    modport source (output valid, func, reg_index, wdata, input ready);
    modport sink   (input valid, func, reg_index, wdata, output ready);
endinterface

interface dee_res_if import dee_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rdata;
    logic              busy_res;
    logic              write_error;
    logic              write_done;

    modport source (output valid, rdata, busy_res, write_error, write_done, input ready);
    modport sink   (input valid, rdata, busy_res, write_error, write_done, output ready);
endinterface

>>> rtl/data_eeprom_controller.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller
// Byte-wide data EEPROM with address, data, control and unlock registers.
// ----------------------------------------------------------------------------
// After reset the block first erases its byte store to 0xFF, one byte per
// cycle, over all 2**ADDR_BITS bytes (1024 by default); no command is
// accepted during that pass, while the write-time register on the APB port can
// be written at any time. After that commands are taken back to back, except
// that a control write with the read bit set while idle holds off the next
// command while the byte comes from the store's synchronous read port. The
// result of a command sits in an output register, so the next command is taken
// while the previous result is still waiting, as long as that register is free
// or being emptied in the same cycle. A timed byte write is counted down by
// tick commands and lands in the store on the last tick.
// ----------------------------------------------------------------------------
module data_eeprom_controller import dee_pkg::*; #(
    parameter int ADDR_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    dee_cmd_if.sink            cmd,
    dee_res_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH = 1 << ADDR_BITS;

    // Sequencer states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic                 wren_reg, wren_next;
    logic [1:0]           unlock_reg, unlock_next;
    logic                 busy_reg, busy_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 err_reg, err_next;
    logic [TICK_W-1:0]    wtt_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_rdata_reg;
    logic                 out_busy_reg;
    logic                 out_err_reg;
    logic                 out_done_reg;

    logic                 accept;
    logic [BYTE_W-1:0]    read_value;
    logic                 done;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 store_write;

    // ------------------------------------------------------------------
    // APB configuration port. Writes decode on the word index only.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_WRITE_TIME) ? {{(PDATA_W-TICK_W){1'b0}}, wtt_reg}
                                                 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtt_reg <= WRITE_TIME_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == CFG_WRITE_TIME))
        begin
            wtt_reg <= pwdata[TICK_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Command handshake. A new command waits while the store is being
    // erased, while a store read is in flight, and while the result
    // register is full and not being taken.
    // ------------------------------------------------------------------
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;

    // Register read mux; the control register shows busy in place of the
    // write bit, and the read bit always reads back as zero.
    always_comb
    begin
        unique case (cmd.reg_index)
            REG_ADDR_HI: read_value = BYTE_W'(addr_reg >> 8);
            REG_ADDR_LO: read_value = addr_reg[7:0];
            REG_DATA:    read_value = data_reg;
            REG_CONTROL:
            begin
                read_value           = '0;
                read_value[CTL_WR]   = busy_reg;
                read_value[CTL_WREN] = wren_reg;
                read_value[CTL_ERR]  = err_reg;
            end
            default:     read_value = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic for one command transaction.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        wren_next    = wren_reg;
        unlock_next  = unlock_reg;
        busy_next    = busy_reg;
        tick_next    = tick_reg;
        err_next     = err_reg;
        done         = 1'b0;
        store_write  = 1'b0;
        ram_re       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_BITS'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // The store byte requested by the read bit is now on the port.
                data_next  = ram_rdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        FUNC_READ:
                        begin
                            unlock_next = STAGE_LOCKED;
                        end
                        FUNC_WRITE:
                        begin
                            unlock_next = STAGE_LOCKED;
                            unique case (cmd.reg_index)
                                REG_ADDR_HI:
                                begin
                                    if (!busy_reg)
                                    begin
                                        addr_next = ADDR_BITS'({cmd.wdata, addr_reg[7:0]});
                                    end
                                end
                                REG_ADDR_LO:
                                begin
                                    if (!busy_reg)
                                    begin
                                        addr_next = ADDR_BITS'({addr_reg >> 8, cmd.wdata});
                                    end
                                end
                                REG_DATA:
                                begin
                                    if (!busy_reg)
                                    begin
                                        data_next = cmd.wdata;
                                    end
                                end
                                REG_CONTROL:
                                begin
                                    // Enable and error clear take effect before
                                    // the write bit is checked.
                                    wren_next = cmd.wdata[CTL_WREN];
                                    if (cmd.wdata[CTL_ERR])
                                    begin
                                        err_next = 1'b0;
                                    end
                                    if (cmd.wdata[CTL_RD] && !busy_reg)
                                    begin
                                        ram_re     = 1'b1;
                                        state_next = ST_READ;
                                    end
                                    if (cmd.wdata[CTL_WR])
                                    begin
                                        if (wren_next && !busy_reg
                                            && (unlock_reg == STAGE_OPEN))
                                        begin
                                            busy_next = 1'b1;
                                            tick_next = (wtt_reg != '0) ? wtt_reg
                                                                         : TICK_W'(1);
                                        end
                                        else
                                        begin
                                            err_next = 1'b1;
                                        end
                                    end
                                end
                                REG_UNLOCK:
                                begin
                                    if (cmd.wdata == UNLOCK_FIRST)
                                    begin
                                        unlock_next = STAGE_FIRST;
                                    end
                                    else if ((cmd.wdata == UNLOCK_SECOND)
                                             && (unlock_reg == STAGE_FIRST))
                                    begin
                                        unlock_next = STAGE_OPEN;
                                    end
                                    else
                                    begin
                                        unlock_next = STAGE_LOCKED;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        FUNC_TICK:
                        begin
                            if (busy_reg)
                            begin
                                if (tick_reg > TICK_W'(1))
                                begin
                                    tick_next = tick_reg - 1'b1;
                                end
                                else
                                begin
                                    tick_next   = '0;
                                    store_write = 1'b1;
                                    busy_next   = 1'b0;
                                    done        = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Store. The erase pass and the end of a timed write share the
    // write port; a read-bit request uses the read port.
    // ------------------------------------------------------------------
    assign ram_we    = (state_reg == ST_CLEAR) || store_write;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? ERASED_BYTE : data_reg;

    dee_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result register. Every command transaction yields one result,
    // formed from the state after that command.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_rdata_reg <= (cmd.func == FUNC_READ) ? read_value : '0;
            out_busy_reg  <= busy_next;
            out_err_reg   <= err_next;
            out_done_reg  <= done;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.rdata       = out_rdata_reg;
    assign res.busy_res    = out_busy_reg;
    assign res.write_error = out_err_reg;
    assign res.write_done  = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            wren_reg      <= 1'b0;
            unlock_reg    <= STAGE_LOCKED;
            busy_reg      <= 1'b0;
            tick_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            wren_reg      <= wren_next;
            unlock_reg    <= unlock_next;
            busy_reg      <= busy_next;
            tick_reg      <= tick_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/dee_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/dee_checker.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller checker
// Port-level checks on result handling and configuration readback.
// ----------------------------------------------------------------------------
`include "data_eeprom_controller_defines.svh"

module dee_props import dee_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [BYTE_W-1:0]  res_rdata,
    input logic               res_busy,
    input logic               res_error,
    input logic               res_done,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata
);

    logic              res_stall;
    logic [BYTE_W+2:0] res_word;
    logic              cfg_wr;
    logic              cfg_rd;

    assign res_stall = res_valid && !res_ready;
    assign res_word  = {res_rdata, res_busy, res_error, res_done};
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == CFG_WRITE_TIME);
    assign cfg_rd    = psel && !pwrite && (paddr[2] == CFG_WRITE_TIME);

    // A stalled result holds its place and contents.
    `DEE_ASSERT(a_res_hold, res_stall |=> (res_valid && $stable(res_word)))

    // A completed write leaves the block idle.
    `DEE_ASSERT_ALWAYS(a_done_not_busy, (res_valid && res_done) |-> !res_busy)

    // The write-time register reads back what was just written to it.
    `DEE_ASSERT(a_cfg_readback, (cfg_wr ##1 cfg_rd) |-> (prdata[TICK_W-1:0] == $past(pwdata[TICK_W-1:0])))

endmodule

bind data_eeprom_controller dee_props u_dee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_rdata (res.rdata),
    .res_busy  (res.busy_res),
    .res_error (res.write_error),
    .res_done  (res.write_done),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

>>> dv/dee_checker.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller checker
// Watches the command, result and APB ports, predicts each response from its
// own copy of the controller state and compares it with what comes out.
// ----------------------------------------------------------------------------
module dee_checker import dee_pkg::*; #(
    parameter int ADDR_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    dee_cmd_if                 cmd,
    dee_res_if                 res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 pending,
    output int                 mismatches
);

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam logic [PADDR_W-1:0] WTIME_ADDR = PADDR_W'(4 * CFG_WRITE_TIME);

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              busy_res;
        logic              write_error;
        logic              write_done;
    } response_t;

    // Shadow of the controller state.
    logic [BYTE_W-1:0]    shadow_store [DEPTH];
    logic [ADDR_BITS-1:0] addr_q;
    logic [BYTE_W-1:0]    data_q;
    logic                 wren_q;
    logic [1:0]           stage_q;
    logic                 busy_q;
    logic [TICK_W-1:0]    ticks_left;
    logic                 err_q;
    logic [TICK_W-1:0]    wtime_q;

    response_t awaited_responses [$];
    response_t got;
    response_t want;
    int        mismatch_count;
    int        response_no;

    function automatic response_t respond_to_access(input logic [FUNC_W-1:0] f,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [BYTE_W-1:0] wd);
        response_t   r;
        logic [15:0] wide_addr;
        r = '0;
        wide_addr = 16'(addr_q);
        case (f)
            FUNC_READ: begin
                case (idx)
                    REG_ADDR_HI: r.rdata = wide_addr[15:8];
                    REG_ADDR_LO: r.rdata = wide_addr[7:0];
                    REG_DATA:    r.rdata = data_q;
                    REG_CONTROL: begin
                        r.rdata[CTL_WR]   = busy_q;
                        r.rdata[CTL_WREN] = wren_q;
                        r.rdata[CTL_ERR]  = err_q;
                    end
                    default:     r.rdata = '0;
                endcase
                stage_q = STAGE_LOCKED;
            end
            FUNC_WRITE: begin
                if (idx == REG_UNLOCK) begin
                    if (wd == UNLOCK_FIRST)
                        stage_q = STAGE_FIRST;
                    else if (wd == UNLOCK_SECOND && stage_q == STAGE_FIRST)
                        stage_q = STAGE_OPEN;
                    else
                        stage_q = STAGE_LOCKED;
                end else begin
                    case (idx)
                        REG_ADDR_HI: if (!busy_q) begin
                            wide_addr[15:8] = wd;
                            addr_q = wide_addr[ADDR_BITS-1:0];
                        end
                        REG_ADDR_LO: if (!busy_q) begin
                            wide_addr[7:0] = wd;
                            addr_q = wide_addr[ADDR_BITS-1:0];
                        end
                        REG_DATA: if (!busy_q) data_q = wd;
                        REG_CONTROL: begin
                            // Enable is taken first, so WR sees the new value.
                            wren_q = wd[CTL_WREN];
                            if (wd[CTL_ERR])
                                err_q = 1'b0;
                            if (wd[CTL_RD] && !busy_q)
                                data_q = shadow_store[addr_q];
                            if (wd[CTL_WR]) begin
                                if (wren_q && !busy_q && stage_q == STAGE_OPEN) begin
                                    busy_q     = 1'b1;
                                    ticks_left = (wtime_q == '0) ? TICK_W'(1) : wtime_q;
                                end else begin
                                    err_q = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    stage_q = STAGE_LOCKED;
                end
            end
            FUNC_TICK: begin
                if (busy_q) begin
                    if (ticks_left > TICK_W'(1)) begin
                        ticks_left = ticks_left - 1'b1;
                    end else begin
                        ticks_left = '0;
                        shadow_store[addr_q] = data_q;
                        busy_q = 1'b0;
                        r.write_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.busy_res    = busy_q;
        r.write_error = err_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                shadow_store[i] = ERASED_BYTE;
            addr_q         = '0;
            data_q         = '0;
            wren_q         = 1'b0;
            stage_q        = STAGE_LOCKED;
            busy_q         = 1'b0;
            ticks_left     = '0;
            err_q          = 1'b0;
            wtime_q        = WRITE_TIME_RESET;
            mismatch_count = 0;
            response_no    = 0;
            awaited_responses.delete();
            pending    <= 0;
            mismatches <= 0;
        end else begin
            if (psel && penable && pready && paddr == WTIME_ADDR) begin
                if (pwrite) begin
                    wtime_q = pwdata[TICK_W-1:0];
                end else if (prdata[TICK_W-1:0] !== wtime_q) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("write time readback: expected %0d, got %0d",
                                 wtime_q, prdata[TICK_W-1:0]);
                end
            end

            if (cmd.valid && cmd.ready)
                awaited_responses.push_back(
                    respond_to_access(cmd.func, cmd.reg_index, cmd.wdata));

            if (res.valid && res.ready) begin
                got.rdata       = res.rdata;
                got.busy_res    = res.busy_res;
                got.write_error = res.write_error;
                got.write_done  = res.write_done;
                if (awaited_responses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("response %0d arrived with none awaited: rdata=%02h busy=%b err=%b done=%b",
                                 response_no, got.rdata, got.busy_res, got.write_error,
                                 got.write_done);
                end else begin
                    want = awaited_responses.pop_front();
                    if (got.rdata !== want.rdata || got.busy_res !== want.busy_res ||
                        got.write_error !== want.write_error ||
                        got.write_done !== want.write_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("response %0d: expected rdata=%02h busy=%b err=%b done=%b, got rdata=%02h busy=%b err=%b done=%b",
                                     response_no, want.rdata, want.busy_res,
                                     want.write_error, want.write_done, got.rdata,
                                     got.busy_res, got.write_error, got.write_done);
                    end
                end
                response_no++;
            end

            pending    <= awaited_responses.size();
            mismatches <= mismatch_count;
        end
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Data EEPROM controller testbench
// Drives register, unlock and tick transactions into the controller, moves the
// write time over the APB port and lets the checker compare every response.
// ----------------------------------------------------------------------------
module tb;
    import dee_pkg::*;

    localparam int ADDR_BITS = 10;
    localparam logic [PADDR_W-1:0] WTIME_ADDR = PADDR_W'(4 * CFG_WRITE_TIME);

    // Function code that the controller does not decode, and a register index
    // that maps to nothing.
    localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [INDEX_W-1:0] REG_SPARE   = 3'd7;

    // Control register bit masks.
    localparam logic [BYTE_W-1:0] RD_BIT   = BYTE_W'(1 << CTL_RD);
    localparam logic [BYTE_W-1:0] WR_BIT   = BYTE_W'(1 << CTL_WR);
    localparam logic [BYTE_W-1:0] WREN_BIT = BYTE_W'(1 << CTL_WREN);
    localparam logic [BYTE_W-1:0] ERR_BIT  = BYTE_W'(1 << CTL_ERR);

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                pending;
    int                mismatches;
    int                sent;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                calm;
    logic [TICK_W-1:0] cur_wtime;

    dee_cmd_if cmd ();
    dee_res_if res ();

    data_eeprom_controller #(.ADDR_BITS(ADDR_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dee_checker #(.ADDR_BITS(ADDR_BITS)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, far beyond the slowest correct run (the store erase plus
    // about a thousand transactions with every stall at its worst).
    initial begin
        #400000;
        $display("FAIL data_eeprom_controller");
        $finish;
    end

    // Result side. The ready line drops in bursts, with the burst rate itself
    // wandering so that there are also stretches without any stall. Once the
    // run goes calm the line stays high.
    initial begin
        res.ready   <= 1'b0;
        rx_idle_pct = 10;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            if ($urandom_range(0, 127) == 0)
                rx_idle_pct = $urandom_range(0, 3) * 6;
        end
    end

    // One command transaction. The task is entered just after a rising edge;
    // it returns at the edge where the transaction was taken, or later if an
    // idle burst follows. Valid stays high between back-to-back transactions.
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] wd);
        cmd.valid     <= 1'b1;
        cmd.func      <= f;
        cmd.reg_index <= idx;
        cmd.wdata     <= wd;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
        if (sent % 64 == 0)
            tx_idle_pct = $urandom_range(0, 3) * 8;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Holds the command side off until every predicted response has come back.
    // The checker's count is registered and lags behind, hence the first wait.
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One APB transfer to the write-time register: a setup cycle, then the
    // access cycle, which completes at the edge where pready is high.
    task automatic apb_access(input logic wr, input logic [TICK_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= WTIME_ADDR;
        pwdata  <= {16'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The write time only changes once every pending response has come back, and each
    // new value is read straight back so that the checker can compare it.
    task automatic set_write_time(input logic [TICK_W-1:0] v);
        drain();
        apb_access(1'b1, v);
        apb_access(1'b0, '0);
        cur_wtime = v;
    endtask

    // Half the addresses come from the two ends of the store, so that bytes
    // are written over and read back often.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] a;
        if ($urandom_range(0, 1)) begin
            a = ADDR_BITS'($urandom);
        end else begin
            a = ADDR_BITS'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
                a = ~a;
        end
        return a;
    endfunction

    // Sometimes a transaction that must not disturb the unlock stage: a tick or an
    // unused function code, both with random content.
    task automatic harmless_item();
        if ($urandom_range(0, 4) == 0)
            send_cmd($urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED,
                     INDEX_W'($urandom), BYTE_W'($urandom));
    endtask

    // A byte write the way firmware does it: address, data, the two unlock
    // bytes, the control write with WREN and WR, then the ticks that time the
    // write. When well_formed is clear one step of the sequence is broken, so
    // the controller must refuse the write and raise its error flag.
    task automatic program_byte(input bit well_formed);
        logic [ADDR_BITS-1:0] addr;
        logic [BYTE_W-1:0]    hi;
        logic [BYTE_W-1:0]    ctl;
        logic [BYTE_W-1:0]    wrong;
        int                   eff;
        int                   ticks;
        addr = pick_address();
        hi   = BYTE_W'($urandom);
        hi[ADDR_BITS-9:0] = addr[ADDR_BITS-1:8];
        eff  = (cur_wtime == '0) ? 1 : int'(cur_wtime);
        ctl  = BYTE_W'($urandom);
        ctl[CTL_WR]   = 1'b1;
        ctl[CTL_WREN] = 1'b1;
        ctl[CTL_RD]   = ($urandom_range(0, 3) == 0);
        send_cmd(FUNC_WRITE, REG_ADDR_HI, hi);
        send_cmd(FUNC_WRITE, REG_ADDR_LO, addr[7:0]);
        send_cmd(FUNC_WRITE, REG_DATA, BYTE_W'($urandom));
        case (well_formed ? 0 : $urandom_range(1, 4))
            0: begin
                // A repeated first unlock byte still leaves the sequence valid.
                if ($urandom_range(0, 4) == 0)
                    send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
                harmless_item();
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
                harmless_item();
            end
            1: send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
            2: begin
                // Any register access between the two bytes relocks.
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
                send_cmd(FUNC_READ, INDEX_W'($urandom), BYTE_W'($urandom));
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
            end
            3: begin
                wrong = BYTE_W'($urandom);
                if (wrong == UNLOCK_SECOND)
                    wrong = '0;
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
                send_cmd(FUNC_WRITE, REG_UNLOCK, wrong);
            end
            default: begin
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
                send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
                ctl[CTL_WREN] = 1'b0;
            end
        endcase
        send_cmd(FUNC_WRITE, REG_CONTROL, ctl);
        // Usually enough ticks to finish, sometimes a few spare; with short
        // write times now and then too few, so the next accesses hit a busy
        // controller.
        ticks = eff + $urandom_range(0, 2);
        if (eff < 100 && $urandom_range(0, 9) == 0)
            ticks = $urandom_range(0, eff);
        repeat (ticks)
            send_cmd(FUNC_TICK, INDEX_W'($urandom), BYTE_W'($urandom));
    endtask

    // Copies a byte from the store into the data register and reads it.
    task automatic fetch_byte();
        logic [ADDR_BITS-1:0] addr;
        logic [BYTE_W-1:0]    hi;
        logic [BYTE_W-1:0]    ctl;
        addr = pick_address();
        hi   = BYTE_W'($urandom);
        hi[ADDR_BITS-9:0] = addr[ADDR_BITS-1:8];
        ctl  = BYTE_W'($urandom);
        ctl[CTL_RD] = 1'b1;
        ctl[CTL_WR] = ($urandom_range(0, 7) == 0);
        send_cmd(FUNC_WRITE, REG_ADDR_HI, hi);
        send_cmd(FUNC_WRITE, REG_ADDR_LO, addr[7:0]);
        send_cmd(FUNC_WRITE, REG_CONTROL, ctl);
        send_cmd(FUNC_READ, REG_DATA, BYTE_W'($urandom));
        if ($urandom_range(0, 1))
            send_cmd(FUNC_READ, INDEX_W'($urandom_range(0, 3)), BYTE_W'($urandom));
    endtask

    // Mostly well-formed writes and read-backs, with broken sequences and
    // random single transactions mixed in.
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        logic [BYTE_W-1:0] wd;
        stop_at = sent + count;
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                program_byte(1'b1);
            end else if (pick < 60) begin
                fetch_byte();
            end else if (pick < 75) begin
                program_byte(1'b0);
            end else begin
                wd = BYTE_W'($urandom);
                if ($urandom_range(0, 3) == 0)
                    wd = $urandom_range(0, 1) ? UNLOCK_FIRST : UNLOCK_SECOND;
                send_cmd(FUNC_W'($urandom_range(0, 3)), INDEX_W'($urandom), wd);
            end
        end
    endtask

    initial begin
        cmd.valid     <= 1'b0;
        cmd.func      <= FUNC_READ;
        cmd.reg_index <= REG_ADDR_HI;
        cmd.wdata     <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rst_n         <= 1'b0;
        calm          = 1'b0;
        sent          = 0;
        tx_idle_pct   = 10;
        cur_wtime     = WRITE_TIME_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The write time can be read while the store is still being erased;
        // it must show its reset value.
        apb_access(1'b0, '0);

        // Directed part, at a short write time. Every register reads its
        // reset value, unused index and function codes do nothing.
        set_write_time(16'd6);
        send_cmd(FUNC_READ, REG_ADDR_HI, 8'h00);
        send_cmd(FUNC_READ, REG_ADDR_LO, 8'hFF);
        send_cmd(FUNC_READ, REG_DATA, 8'h00);
        send_cmd(FUNC_READ, REG_CONTROL, 8'h00);
        send_cmd(FUNC_READ, REG_UNLOCK, 8'h00);
        send_cmd(FUNC_READ, REG_SPARE, 8'h00);
        send_cmd(FUNC_UNUSED, REG_SPARE, 8'hFF);
        // Address high keeps only its low bits.
        send_cmd(FUNC_WRITE, REG_ADDR_HI, 8'hFF);
        send_cmd(FUNC_WRITE, REG_ADDR_LO, 8'hFF);
        send_cmd(FUNC_READ, REG_ADDR_HI, 8'h00);
        // A read of the erased store, then a new data byte.
        send_cmd(FUNC_WRITE, REG_CONTROL, RD_BIT);
        send_cmd(FUNC_READ, REG_DATA, 8'h00);
        send_cmd(FUNC_WRITE, REG_DATA, 8'h3C);
        // WR with neither unlock nor enable raises the error flag, and writing
        // one to the error bit clears it again.
        send_cmd(FUNC_WRITE, REG_CONTROL, WR_BIT);
        send_cmd(FUNC_READ, REG_CONTROL, 8'h00);
        send_cmd(FUNC_WRITE, REG_CONTROL, ERR_BIT | WREN_BIT);
        // A proper unlock starts the timed write.
        send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
        send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
        send_cmd(FUNC_WRITE, REG_CONTROL, WREN_BIT | WR_BIT);
        // While busy the address, the data and the read bit are frozen, and
        // another WR is an error even after a fresh unlock.
        send_cmd(FUNC_WRITE, REG_ADDR_LO, 8'h00);
        send_cmd(FUNC_WRITE, REG_DATA, 8'hFF);
        send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_FIRST);
        send_cmd(FUNC_WRITE, REG_UNLOCK, UNLOCK_SECOND);
        send_cmd(FUNC_WRITE, REG_CONTROL, RD_BIT | WREN_BIT | WR_BIT);
        send_cmd(FUNC_WRITE, REG_SPARE, 8'hFF);
        send_cmd(FUNC_WRITE, REG_CONTROL, ERR_BIT | WREN_BIT);

        // Let the write time run out, then read the byte back.
        repeat (int'(cur_wtime))
            send_cmd(FUNC_TICK, INDEX_W'($urandom), BYTE_W'($urandom));
        send_cmd(FUNC_WRITE, REG_CONTROL, RD_BIT);
        send_cmd(FUNC_READ, REG_DATA, 8'h00);

        // Random part over several short write times, zero among them. Each
        // change of setting first waits for the controller to go quiet.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_write_time(16'd1);
                1: set_write_time(16'd0);
                2: set_write_time(16'd3);
                3: set_write_time(16'd2);
                4: set_write_time(TICK_W'($urandom_range(4, 15)));
                default: set_write_time(16'd1);
            endcase
            run_random(110);
        end

        // Spare ticks first make sure no write from the random part is still
        // pending. The largest write time must read back whole, then one full
        // write runs at a longer setting than in the random part.
        repeat (20)
            send_cmd(FUNC_TICK, INDEX_W'($urandom), BYTE_W'($urandom));
        calm = 1'b1;
        set_write_time(16'hFFFF);
        set_write_time(16'd40);
        program_byte(1'b1);
        fetch_byte();

        // Closing stretch without any idling on either side.
        set_write_time(16'd2);
        run_random(100);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS data_eeprom_controller");
        else
            $display("FAIL data_eeprom_controller");
        $finish;
    end

endmodule
